// ===== sv/matd_pkg.sv =====
`timescale 1ns / 1ps

package matd_pkg;

  // field and register widths
  localparam int PIX_W          = 8;
  localparam int SAD_W          = 10;
  localparam int FRAME_PIXELS_W = 20;
  localparam int GAIN_W         = 24;
  localparam int CFG_DATA_W     = 24;
  localparam int CFG_INDEX_W    = 1;
  localparam int PROD_W         = GAIN_W + SAD_W;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_PIXELS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOTION_GAIN  = 1'b1;

  // register reset values
  localparam logic [FRAME_PIXELS_W-1:0] FRAME_PIXELS_RST = 20'd307200;
  localparam logic [GAIN_W-1:0]         MOTION_GAIN_RST  = 24'd655;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  // one pixel in, bgr with blue in the low byte
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } matd_in_t;

  // one filtered pixel out with its motion figures
  typedef struct packed {
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] diff_blue;
    logic [PIX_W-1:0] diff_green;
    logic [PIX_W-1:0] diff_red;
    logic [PIX_W-1:0] sad_clamped;
    logic             frame_last;
  } matd_out_t;

endpackage

// ===== sv/motion_adaptive_temporal_denoise_top.sv =====
`timescale 1ns / 1ps

// channel   signals                          transfer when
// ------    -------------------------------  ----------------------
// input     in_valid, in_ready, in_data      in_valid & in_ready
// result    out_valid, out_ready, out_data   out_valid & out_ready
// config    cfg_wr_en, cfg_index, cfg_data   cfg_wr_en
//
// one pixel per clock while the result is not stalled and no pixel waits on the store;
// five register stages (store read, sad, gain multiply, weight, blend into the result
// register). the frame store holds one port read and one port write per cycle;
// when a frame is at most four pixels long a pixel waits until the one ahead of it at
// the same location has written back. rst_n clears control state only; the store is not
// cleared and is filled by the first frame. a stalled result freezes all stages.

module motion_adaptive_temporal_denoise_top
  import matd_pkg::*;
#(
  parameter int STORE_PIXELS     = 524288,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  matd_in_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output matd_out_t              out_data,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int W   = WEIGHT_FRAC_BITS;
  localparam int PW  = (STORE_PIXELS > 1) ? $clog2(STORE_PIXELS) : 1;
  localparam int NW  = (PW + 1 > FRAME_PIXELS_W) ? PW + 1 : FRAME_PIXELS_W;
  localparam int LSH = (W >= 17) ? W - 17 : 0;
  localparam int RSH = (W >= 17) ? 0 : 17 - W;
  localparam int RW  = PROD_W + LSH;
  localparam logic [W-1:0]  HALF  = W'(1) << (W - 1);
  localparam logic [W:0]    ONE   = (W + 1)'(1) << W;
  localparam logic [NW-1:0] STORE_N = NW'(STORE_PIXELS);

  typedef logic [2:0][PIX_W-1:0] pix_t;

  // configuration registers
  logic [FRAME_PIXELS_W-1:0] frame_pixels_r;
  logic [GAIN_W-1:0]         motion_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_pixels_r <= FRAME_PIXELS_RST;
      motion_gain_r  <= MOTION_GAIN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_PIXELS: frame_pixels_r <= cfg_data[FRAME_PIXELS_W-1:0];
        CFG_MOTION_GAIN:  motion_gain_r  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline registers
  logic [PW-1:0] position_r, position_nxt;
  logic          have_prev_r, have_prev_nxt;

  logic          s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  pix_t          s1_cur_r, s2_cur_r, s3_cur_r, s4_cur_r;
  pix_t          rd_data_r, s2_prev_r, s3_prev_r, s4_prev_r;
  pix_t          s2_dif_r, s3_dif_r, s4_dif_r;
  logic [SAD_W-1:0] s2_sad_r, s3_sad_r, s4_sad_r;
  logic [PW-1:0] s1_pos_r, s2_pos_r, s3_pos_r, s4_pos_r;
  logic          s1_last_r, s2_last_r, s3_last_r, s4_last_r;
  logic          s1_first_r, s2_first_r, s3_first_r, s4_first_r;
  logic [PROD_W-1:0] s3_prod_r;
  logic [W-1:0]  s4_weight_r;
  matd_out_t     out_data_r;

  pix_t          store_mem [STORE_PIXELS];

  logic          adv, hazard, in_xfer, in_last;
  logic [NW-1:0] frame_n, fp_ext, pos_inc;

  // frame length and end of frame
  always_comb begin
    fp_ext  = NW'(frame_pixels_r);
    frame_n = fp_ext;
    if (fp_ext == '0) begin
      frame_n = NW'(1);
    end else if (fp_ext > STORE_N) begin
      frame_n = STORE_N;
    end
    pos_inc = NW'(position_r) + NW'(1);
    in_last = (pos_inc >= frame_n);
  end

  // a pixel waits while an earlier one at the same location is still in flight
  always_comb begin
    hazard = have_prev_r &&
             ((s1_valid_r && s1_pos_r == position_r) ||
              (s2_valid_r && s2_pos_r == position_r) ||
              (s3_valid_r && s3_pos_r == position_r) ||
              (s4_valid_r && s4_pos_r == position_r));
  end

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv && !hazard;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // raster position and first frame flag
  always_comb begin
    position_nxt  = position_r;
    have_prev_nxt = have_prev_r;
    if (in_xfer) begin
      if (in_last) begin
        position_nxt  = '0;
        have_prev_nxt = 1'b1;
      end else begin
        position_nxt = position_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r  <= '0;
      have_prev_r <= 1'b0;
    end else begin
      position_r  <= position_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_xfer;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // stage 1: frame store read
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data_r  <= store_mem[position_r];
      s1_cur_r   <= in_data;
      s1_pos_r   <= position_r;
      s1_last_r  <= in_last;
      s1_first_r <= !have_prev_r;
    end
  end

  // stage 2: per channel differences and sad
  pix_t             dif;
  logic [SAD_W-1:0] sad;

  always_comb begin
    sad = '0;
    for (int i = 0; i < 3; i++) begin
      if (s1_first_r) begin
        dif[i] = '0;
      end else if (rd_data_r[i] > s1_cur_r[i]) begin
        dif[i] = rd_data_r[i] - s1_cur_r[i];
      end else begin
        dif[i] = s1_cur_r[i] - rd_data_r[i];
      end
      sad = sad + SAD_W'(dif[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cur_r   <= s1_cur_r;
      s2_prev_r  <= rd_data_r;
      s2_dif_r   <= dif;
      s2_sad_r   <= sad;
      s2_pos_r   <= s1_pos_r;
      s2_last_r  <= s1_last_r;
      s2_first_r <= s1_first_r;
    end
  end

  // stage 3: gain times sad
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_prod_r  <= PROD_W'(motion_gain_r) * PROD_W'(s2_sad_r);
      s3_cur_r   <= s2_cur_r;
      s3_prev_r  <= s2_prev_r;
      s3_dif_r   <= s2_dif_r;
      s3_sad_r   <= s2_sad_r;
      s3_pos_r   <= s2_pos_r;
      s3_last_r  <= s2_last_r;
      s3_first_r <= s2_first_r;
    end
  end

  // stage 4: halve, scale to weight fraction and saturate at one half
  logic [RW-1:0] red;
  logic [W-1:0]  weight;

  always_comb begin
    red = (RW'(s3_prod_r) << LSH) >> RSH;
    if (red > RW'(HALF)) begin
      weight = '0;
    end else begin
      weight = HALF - W'(red);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_weight_r <= weight;
      s4_cur_r    <= s3_cur_r;
      s4_prev_r   <= s3_prev_r;
      s4_dif_r    <= s3_dif_r;
      s4_sad_r    <= s3_sad_r;
      s4_pos_r    <= s3_pos_r;
      s4_last_r   <= s3_last_r;
      s4_first_r  <= s3_first_r;
    end
  end

  // stage 5: blend, write back and result register
  logic [W:0]   inv_w;
  logic [W+8:0] acc [3];
  pix_t         res;

  always_comb begin
    inv_w = ONE - {1'b0, s4_weight_r};
    for (int i = 0; i < 3; i++) begin
      acc[i] = (W + 9)'(s4_weight_r) * (W + 9)'(s4_prev_r[i]) +
               (W + 9)'(inv_w) * (W + 9)'(s4_cur_r[i]);
      if (s4_first_r) begin
        res[i] = s4_cur_r[i];
      end else begin
        res[i] = acc[i][W+7:W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s4_valid_r) begin
      store_mem[s4_pos_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.out_blue    <= res[0];
      out_data_r.out_green   <= res[1];
      out_data_r.out_red     <= res[2];
      out_data_r.diff_blue   <= s4_dif_r[0];
      out_data_r.diff_green  <= s4_dif_r[1];
      out_data_r.diff_red    <= s4_dif_r[2];
      out_data_r.sad_clamped <= (s4_sad_r > SAD_W'(PIX_MAX)) ? PIX_MAX
                                                             : s4_sad_r[PIX_W-1:0];
      out_data_r.frame_last  <= s4_last_r;
    end
  end

endmodule
